### sv/pal_pkg.sv
// Shared types and codes for the positional array list.
// Used by pal_cell, positional_array_list and the test bench; depends on nothing else.

package pal_pkg;

    // Field widths fixed by the stream interface.
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_ELEM_WIDTH  = 32;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Update command broadcast to every cell in the apply cycle.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write_en;
    } apply_cmd_t;

endpackage

### sv/pal_cell.sv
// One list slot: holds a single entry and passes the scan record to its neighbor.
// Depends on pal_pkg for the update command struct and the default element width.

module pal_cell #(
    parameter int CELL_INDEX = 0,
    parameter int ELEM_WIDTH = pal_pkg::DEF_ELEM_WIDTH,
    parameter int CMP_WIDTH  = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pal_pkg::apply_cmd_t    cmd,
    input  logic [CMP_WIDTH-1:0]   sel_idx,
    input  logic [CMP_WIDTH-1:0]   count,
    input  logic [ELEM_WIDTH-1:0]  key,
    input  logic [ELEM_WIDTH-1:0]  left_entry,
    input  logic [ELEM_WIDTH-1:0]  right_entry,
    output logic [ELEM_WIDTH-1:0]  entry,
    input  logic                   carry_in_valid,
    input  logic                   carry_in_hit,
    input  logic [ELEM_WIDTH-1:0]  carry_in_data,
    input  logic [CMP_WIDTH-1:0]   carry_in_found,
    output logic                   carry_out_valid,
    output logic                   carry_out_hit,
    output logic [ELEM_WIDTH-1:0]  carry_out_data,
    output logic [CMP_WIDTH-1:0]   carry_out_found
);

    localparam logic [CMP_WIDTH-1:0] MY_IDX = CMP_WIDTH'(CELL_INDEX);
    localparam logic [CMP_WIDTH-1:0] MY_POS = CMP_WIDTH'(CELL_INDEX + 1);

    logic [ELEM_WIDTH-1:0] entry_reg, entry_next;
    logic                  valid_reg;
    logic                  hit_reg, hit_next;
    logic [ELEM_WIDTH-1:0] data_reg, data_next;
    logic [CMP_WIDTH-1:0]  found_reg, found_next;
    logic                  is_sel, above_sel, in_use, match;

    // Position of this slot relative to the request.
    always_comb begin
        is_sel    = (MY_IDX == sel_idx);
        above_sel = (MY_IDX > sel_idx);
        in_use    = (MY_IDX < count);
        match     = (entry_reg == key);
    end

    // Entry update: shift from a neighbor or take the new value.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_up) begin
            if (above_sel) begin
                entry_next = left_entry;
            end else if (is_sel) begin
                entry_next = key;
            end
        end else if (cmd.shift_down) begin
            if (is_sel || above_sel) begin
                entry_next = right_entry;
            end
        end else if (cmd.write_en && is_sel) begin
            entry_next = key;
        end
    end

    // Scan record: pick up the selected entry and the first match.
    always_comb begin
        hit_next   = carry_in_hit;
        data_next  = carry_in_data;
        found_next = carry_in_found;
        if (is_sel) begin
            data_next = entry_reg;
        end
        if (!carry_in_hit && in_use && match) begin
            hit_next   = 1'b1;
            found_next = MY_POS;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // The record payload only moves with a valid transfer, so the last
    // cell holds its result until the sequencer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= carry_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (carry_in_valid) begin
            hit_reg   <= hit_next;
            data_reg  <= data_next;
            found_reg <= found_next;
        end
    end

    assign entry           = entry_reg;
    assign carry_out_valid = valid_reg;
    assign carry_out_hit   = hit_reg;
    assign carry_out_data  = data_reg;
    assign carry_out_found = found_reg;

endmodule

### sv/positional_array_list.sv
// Positional array list: a row of pal_cell slots with a scan-and-apply sequencer.
// A request is accepted in ST_IDLE, scanned in ST_SCAN and its result stored in ST_DONE;
// the next request is accepted only after that store. The scan record walks the cell row
// one slot per cycle. The result is stored, once the output register is free, in that register,
// which frees the input side while the result waits. Reset (aresetn low, synchronous)
// empties the list and sets capacity_limit to 16; entry contents are not cleared.

module positional_array_list #(
    parameter int MAX_ENTRIES = pal_pkg::DEF_MAX_ENTRIES,
    parameter int ELEM_WIDTH  = pal_pkg::DEF_ELEM_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Capacity register write.
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,    // capacity_limit
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // [4:0] position, [36:5] value, [39:37] zero
    input  logic [2:0]  s_tuser,      // [2:0] operation
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // [31:0] data_out, [36:32] found_position,
                                      // [41:37] entry_count, [47:42] zero
    output logic [2:0]  m_tuser       // [2:0] status
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;
    localparam logic [CMPW-1:0] MAX_X = CMPW'(MAX_ENTRIES);

    pal_pkg::state_t state_reg, state_next;

    logic [pal_pkg::CAP_W-1:0]   cap_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic [pal_pkg::OP_W-1:0]    op_reg;
    logic [pal_pkg::POS_W-1:0]   pos_reg;
    logic [ELEM_WIDTH-1:0]       key_reg;
    logic                        launch_reg;

    logic                        m_valid_reg;
    logic [pal_pkg::STATUS_W-1:0] m_status_reg;
    logic [31:0]                 m_data_reg;
    logic [4:0]                  m_found_reg;
    logic [4:0]                  m_count_reg;

    logic                        accept, out_free, done_fire;
    logic [63:0]                 value_ext;
    logic [CMPW-1:0]             cnt_x, pos_x, cap_x, sel_idx;

    pal_pkg::status_t            res_status;
    logic                        res_data_sel;
    logic                        res_found_sel;
    pal_pkg::apply_cmd_t         res_cmd, cmd;
    logic [CW-1:0]               res_count;
    logic [63:0]                 data_ext;
    logic [CMPW-1:0]             count_ext;

    logic [ELEM_WIDTH-1:0]       entry_bus [MAX_ENTRIES];
    logic                        c_valid [MAX_ENTRIES];
    logic                        c_hit   [MAX_ENTRIES];
    logic [ELEM_WIDTH-1:0]       c_data  [MAX_ENTRIES];
    logic [CMPW-1:0]             c_found [MAX_ENTRIES];

    // Handshake qualifiers.
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign value_ext = 64'($signed(s_tdata[36:5]));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pal_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pal_pkg::ST_SCAN;
                end
            end
            pal_pkg::ST_SCAN: begin
                if (c_valid[MAX_ENTRIES-1]) begin
                    state_next = pal_pkg::ST_DONE;
                end
            end
            pal_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pal_pkg::ST_IDLE;
                end
            end
            default: state_next = pal_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        done_fire = 1'b0;
        case (state_reg)
            pal_pkg::ST_IDLE: s_tready  = 1'b1;
            pal_pkg::ST_SCAN: s_tready  = 1'b0;
            pal_pkg::ST_DONE: done_fire = out_free;
            default: begin
                s_tready  = 1'b0;
                done_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pal_pkg::ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= accept;
        end
    end

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= pal_pkg::CAP_W'(pal_pkg::CAP_RESET);
        end else if (cfg_wen) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Request holding registers, loaded on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser;
            pos_reg <= s_tdata[4:0];
            key_reg <= value_ext[ELEM_WIDTH-1:0];
        end
    end

    // Comparisons are made at a common width.
    always_comb begin
        cnt_x   = CMPW'(count_reg);
        pos_x   = CMPW'(pos_reg);
        cap_x   = CMPW'(cap_reg);
        sel_idx = pos_x - CMPW'(1);
    end

    // Status and update decision, taken once the scan record is back.
    always_comb begin
        res_status    = pal_pkg::STAT_OK;
        res_data_sel  = 1'b0;
        res_found_sel = 1'b0;
        res_cmd       = '0;
        res_count     = count_reg;
        case (op_reg)
            pal_pkg::OP_INSERT: begin
                if (cnt_x >= cap_x || cnt_x >= MAX_X) begin
                    res_status = pal_pkg::STAT_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                    res_status = pal_pkg::STAT_BADPOS;
                end else begin
                    res_cmd.shift_up = 1'b1;
                    res_count        = count_reg + CW'(1);
                end
            end
            pal_pkg::OP_DELETE, pal_pkg::OP_READ, pal_pkg::OP_WRITE: begin
                if (cnt_x == '0) begin
                    res_status = pal_pkg::STAT_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    res_status = pal_pkg::STAT_BADPOS;
                end else if (op_reg == pal_pkg::OP_DELETE) begin
                    res_data_sel       = 1'b1;
                    res_cmd.shift_down = 1'b1;
                    res_count          = count_reg - CW'(1);
                end else if (op_reg == pal_pkg::OP_READ) begin
                    res_data_sel = 1'b1;
                end else begin
                    res_cmd.write_en = 1'b1;
                end
            end
            pal_pkg::OP_SEARCH: begin
                if (c_hit[MAX_ENTRIES-1]) begin
                    res_found_sel = 1'b1;
                end else begin
                    res_status = pal_pkg::STAT_NOTFOUND;
                end
            end
            default: res_status = pal_pkg::STAT_BADPOS;
        endcase
    end

    // The update reaches the cells only in the cycle the result is stored.
    always_comb begin
        cmd = done_fire ? res_cmd : '0;
        count_next = done_fire ? res_count : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result formatting: missing data reads as all ones.
    always_comb begin
        if (res_data_sel) begin
            data_ext = 64'($signed(c_data[MAX_ENTRIES-1]));
        end else begin
            data_ext = '1;
        end
        count_ext = CMPW'(res_count);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            m_status_reg <= res_status;
            m_data_reg   <= data_ext[31:0];
            m_found_reg  <= res_found_sel ? c_found[MAX_ENTRIES-1][4:0] : 5'd0;
            m_count_reg  <= count_ext[4:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_found_reg, m_data_reg};

    // Row of cells; the scan record enters at the first slot.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] left_w, right_w, cin_data;
        logic                  cin_valid, cin_hit;
        logic [CMPW-1:0]       cin_found;

        if (g == 0) begin : g_head
            assign left_w    = key_reg;
            assign cin_valid = launch_reg;
            assign cin_hit   = 1'b0;
            assign cin_data  = '1;
            assign cin_found = '0;
        end else begin : g_body
            assign left_w    = entry_bus[g-1];
            assign cin_valid = c_valid[g-1];
            assign cin_hit   = c_hit[g-1];
            assign cin_data  = c_data[g-1];
            assign cin_found = c_found[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign right_w = entry_bus[g];
        end else begin : g_inner
            assign right_w = entry_bus[g+1];
        end

        pal_cell #(
            .CELL_INDEX (g),
            .ELEM_WIDTH (ELEM_WIDTH),
            .CMP_WIDTH  (CMPW)
        ) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .cmd             (cmd),
            .sel_idx         (sel_idx),
            .count           (cnt_x),
            .key             (key_reg),
            .left_entry      (left_w),
            .right_entry     (right_w),
            .entry           (entry_bus[g]),
            .carry_in_valid  (cin_valid),
            .carry_in_hit    (cin_hit),
            .carry_in_data   (cin_data),
            .carry_in_found  (cin_found),
            .carry_out_valid (c_valid[g]),
            .carry_out_hit   (c_hit[g]),
            .carry_out_data  (c_data[g]),
            .carry_out_found (c_found[g])
        );
    end

endmodule

### test/pal_checker.sv
// Checker for the positional array list: watches the capacity port and both streams,
// predicts every result from its own copy of the list and compares field by field.
// Depends on pal_pkg for the request and status codes.

module pal_list_checker
    import pal_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          held,
    output int          results_checked
);

    // One result transfer, unpacked.
    typedef struct packed {
        status_t     st;
        logic [31:0] data;
        logic [4:0]  fpos;
        logic [4:0]  cnt;
    } list_result_t;

    // Shadow copy of the list and its capacity register.
    logic [31:0]  slots [MAX_ENTRIES];
    int           fill;
    int           capacity;
    list_result_t pending_results [$];
    int           bad;
    int           checked;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic list_result_t apply_request(logic [2:0] op_bits, logic [4:0] pos,
                                                   logic [31:0] val);
        list_result_t r;
        int lim;
        int p;
        int i;
        r.st   = STAT_OK;
        r.data = '1;
        r.fpos = '0;
        p      = int'(pos);
        lim    = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
        case (op_bits)
            OP_INSERT: begin
                // Full is checked before the position.
                if (fill >= lim) begin
                    r.st = STAT_FULL;
                end else if (p < 1 || p > fill + 1) begin
                    r.st = STAT_BADPOS;
                end else begin
                    for (i = fill; i >= p; i--)
                        slots[i] = slots[i-1];
                    slots[p-1] = val;
                    fill++;
                end
            end
            OP_DELETE, OP_READ, OP_WRITE: begin
                if (fill == 0) begin
                    r.st = STAT_EMPTY;
                end else if (p < 1 || p > fill) begin
                    r.st = STAT_BADPOS;
                end else if (op_bits == OP_DELETE) begin
                    r.data = slots[p-1];
                    for (i = p; i < fill; i++)
                        slots[i-1] = slots[i];
                    fill--;
                end else if (op_bits == OP_READ) begin
                    r.data = slots[p-1];
                end else begin
                    slots[p-1] = val;
                end
            end
            OP_SEARCH: begin
                // The first match wins; an empty list simply finds nothing.
                r.st = STAT_NOTFOUND;
                for (i = 0; i < fill; i++) begin
                    if (slots[i] == val && r.st == STAT_NOTFOUND) begin
                        r.st   = STAT_OK;
                        r.fpos = 5'(i + 1);
                    end
                end
            end
            default: begin
                // Unknown codes are rejected without touching the list.
                r.st = STAT_BADPOS;
            end
        endcase
        r.cnt = 5'(fill);
        return r;
    endfunction

    // Predict on every accepted request, then compare every accepted result.
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            fill     = 0;
            capacity = CAP_RESET;
            pending_results.delete();
        end else begin
            if (cfg_wen)
                capacity = int'(cfg_wdata);
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(s_tuser, s_tdata[4:0],
                                                        s_tdata[36:5]));
            if (m_tvalid && m_tready) begin
                got.st   = status_t'(m_tuser);
                got.data = m_tdata[31:0];
                got.fpos = m_tdata[36:32];
                got.cnt  = m_tdata[41:37];
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request waiting: status %0d data %h",
                           m_tuser, got.data);
                    bad++;
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (got.st !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, got.st);
                        bad++;
                    end
                    if (got.data !== want.data) begin
                        $error("data_out: expected %h, got %h", want.data, got.data);
                        bad++;
                    end
                    if (got.fpos !== want.fpos) begin
                        $error("found_position: expected %0d, got %0d", want.fpos, got.fpos);
                        bad++;
                    end
                    if (got.cnt !== want.cnt) begin
                        $error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
                        bad++;
                    end
                end
            end
        end
        mismatches      <= bad;
        outstanding     <= pending_results.size();
        held            <= fill;
        results_checked <= checked;
    end

endmodule

### test/tb.sv
// Top of the positional array list testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pal_pkg, the block and pal_list_checker.

module tb;
    import pal_pkg::*;

    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int SETTLE      = MAX_ENTRIES + 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {FILL_HEAVY, DRAIN_HEAVY, BALANCED} traffic_mix_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    int mismatches;
    int outstanding;
    int held;
    int results_checked;

    // Stimulus bookkeeping.
    bit          steady = 1'b0;
    int          sent = 0;
    int          directed_sent = 0;
    int          settings_seen = 0;
    int          cycles = 0;
    logic [31:0] recent_values [8];
    int          recent_wr = 0;

    positional_array_list DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pal_list_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .held            (held),
        .results_checked (results_checked)
    );

    // Clock with a period of 8.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each transfer,
    // except in steady phases.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Offers one request after a random gap and holds it until the transfer.
    task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
                                input logic [31:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, val, pos};
        do @(posedge aclk); while (!s_tready);
        sent++;
        recent_values[recent_wr] = val;
        recent_wr = (recent_wr + 1) % 8;
    endtask

    // Stops offering requests until every result is back and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Capacity writes happen only while the list engine is idle.
    task automatic set_capacity(input logic [4:0] cap);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        settings_seen++;
    endtask

    // Values are biased toward recent ones so that searches hit.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return recent_values[$urandom_range(0, 7)];
        if (roll == 5)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // One random request: mostly well-formed for the current fill level, some noise.
    task automatic random_request(input traffic_mix_t mix);
        int n;
        int roll;
        int ins_w;
        int del_w;
        logic [2:0] op;
        logic [4:0] pos;
        n = held;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            op  = 3'($urandom_range(0, 7));
            pos = 5'($urandom_range(0, 31));
        end else begin
            case (mix)
                FILL_HEAVY:  begin ins_w = 55; del_w = 10; end
                DRAIN_HEAVY: begin ins_w = 10; del_w = 55; end
                default:     begin ins_w = 30; del_w = 25; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_w)
                op = OP_INSERT;
            else if (roll < ins_w + del_w)
                op = OP_DELETE;
            else if (roll < ins_w + del_w + (100 - ins_w - del_w) / 3)
                op = OP_READ;
            else if (roll < ins_w + del_w + 2 * (100 - ins_w - del_w) / 3)
                op = OP_WRITE;
            else
                op = OP_SEARCH;
            if (op == OP_INSERT)
                pos = 5'($urandom_range(1, n + 1));
            else if (n == 0)
                pos = 5'($urandom_range(1, 3));
            else
                pos = 5'($urandom_range(1, n));
        end
        send_request(op, pos, pick_value());
    endtask

    // Main sequence: reset, directed corner cases, then random phases.
    initial begin
        int rand_sent;
        int phase_len;
        int roll;
        logic [4:0] cap;
        traffic_mix_t mix;

        foreach (recent_values[k])
            recent_values[k] = $urandom;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Requests against an empty list.
        send_request(OP_SEARCH, 5'd5, 32'h0000_0005);
        send_request(OP_READ,   5'd1, 32'h0);
        send_request(OP_DELETE, 5'd1, 32'h0);
        send_request(OP_WRITE,  5'd1, 32'h1);
        // Insert positions out of range, then inserts at the front, end and middle.
        send_request(OP_INSERT, 5'd0, 32'h1);
        send_request(OP_INSERT, 5'd2, 32'h1);
        send_request(OP_INSERT, 5'd1, 32'h8000_0000);
        send_request(OP_INSERT, 5'd1, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 5'd3, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 5'd2, 32'h0);
        send_request(OP_READ,   5'd4, 32'h0);
        send_request(OP_READ,   5'd5, 32'h0);
        send_request(OP_WRITE,  5'd2, 32'hFFFF_FFFF);
        // Two copies of all ones: the search must report the first.
        send_request(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 5'd0, 32'h55AA_55AA);
        // Codes outside the operation set.
        send_request(3'd5, 5'd1, 32'h0);
        send_request(3'd6, 5'd2, 32'h0);
        send_request(3'd7, 5'd31, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 5'd4, 32'h0);
        send_request(OP_DELETE, 5'd0, 32'h0);
        send_request(OP_DELETE, 5'd1, 32'h0);
        // Capacity lowered to the fill level, then to zero.
        settle();
        set_capacity(5'd2);
        send_request(OP_INSERT, 5'd1, 32'h1234_5678);
        settle();
        set_capacity(5'd0);
        send_request(OP_INSERT, 5'd1, 32'h1234_5678);
        send_request(OP_DELETE, 5'd2, 32'h0);
        directed_sent = sent;

        // Random phases, each under its own capacity; the first few are fixed extremes.
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            settle();
            case (settings_seen)
                2:       cap = 5'd31;
                3:       cap = 5'd1;
                4:       cap = 5'd16;
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0)
                        cap = 5'd0;
                    else if (roll == 1)
                        cap = 5'd1;
                    else if (roll == 2)
                        cap = 5'd16;
                    else if (roll == 3)
                        cap = 5'($urandom_range(17, 31));
                    else
                        cap = 5'($urandom_range(2, 15));
                end
            endcase
            set_capacity(cap);
            steady = ($urandom_range(0, 3) == 0);
            mix = traffic_mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                random_request(mix);
                rand_sent++;
            end
        end
        steady = 1'b0;
        settle();

        $display("Sent %0d requests (%0d directed) and checked %0d results",
                 sent, directed_sent, results_checked);
        $display("Visited %0d capacity settings, including zero, one and saturating values",
                 settings_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
